>>> rtl/csrgb_pkg.sv
// Shared types and constants for the component sample to RGB8 converter.
// No dependencies; imported by the scaler, the color converter and the top level.
`timescale 1ns / 1ps

package csrgb_pkg;

  localparam int unsigned RawW  = 17;
  localparam int unsigned PrecW = 5;
  localparam int unsigned CompW = 8;
  localparam int unsigned SumW  = 27;

  // Q.16 coefficients of the BT.601 YCbCr to RGB conversion.
  localparam logic signed [SumW-1:0] CoefCrR = 27'sd91881;
  localparam logic signed [SumW-1:0] CoefCbG = 27'sd22554;
  localparam logic signed [SumW-1:0] CoefCrG = 27'sd46802;
  localparam logic signed [SumW-1:0] CoefCbB = 27'sd116130;
  localparam logic signed [SumW-1:0] ChromaOffset = 27'sd128;

  typedef enum logic [2:0] {
    RegPrecFirst  = 3'd0,
    RegPrecSecond = 3'd1,
    RegPrecThird  = 3'd2,
    RegSignedMask = 3'd3,
    RegYccConvert = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CompW-1:0] red;
    logic [CompW-1:0] green;
    logic [CompW-1:0] blue;
  } rgb_t;

  // Negative sums give zero; otherwise floor of the Q.16 value, saturated to 255.
  function automatic logic [CompW-1:0] q16_to_byte(logic signed [SumW-1:0] s);
    logic [CompW-1:0] res;
    if (s < 0) begin
      res = '0;
    end else if (s[SumW-1:16] > 11'd255) begin
      res = '1;
    end else begin
      res = s[23:16];
    end
    return res;
  endfunction

endpackage

>>> rtl/csrgb_scale.sv
// One component scaler: signed offset, clamp to the precision, scale to 8 bits.
// Depends on csrgb_pkg.
`timescale 1ns / 1ps

module csrgb_scale #(
  parameter int unsigned MaxPrec = 16
) (
  input  logic signed [csrgb_pkg::RawW-1:0]  raw_i,
  input  logic        [csrgb_pkg::PrecW-1:0] prec_i,
  input  logic                               sgn_i,
  output logic        [csrgb_pkg::CompW-1:0] comp_o
);
  import csrgb_pkg::*;

  logic        [PrecW-1:0] p_eff;
  logic signed [RawW:0]    raw_ext;
  logic        [RawW:0]    bias;
  logic signed [RawW:0]    biased;
  logic        [15:0]      maxv;
  logic        [15:0]      clamped;
  logic        [15:0]      shifted;

  always_comb begin
    if (prec_i == '0) begin
      p_eff = PrecW'(1);
    end else if (prec_i > PrecW'(MaxPrec)) begin
      p_eff = PrecW'(MaxPrec);
    end else begin
      p_eff = prec_i;
    end
  end

  assign raw_ext = (RawW+1)'(raw_i);
  assign bias    = sgn_i ? ((RawW+1)'(1) << (p_eff - PrecW'(1))) : '0;
  assign biased  = raw_ext + signed'(bias);
  assign maxv    = 16'((17'(1) << p_eff) - 17'd1);

  always_comb begin
    if (biased < 0) begin
      clamped = '0;
    end else if (biased > signed'({2'b00, maxv})) begin
      clamped = maxv;
    end else begin
      clamped = biased[15:0];
    end
  end

  always_comb begin
    if (p_eff >= PrecW'(8)) begin
      shifted = clamped >> (p_eff - PrecW'(8));
    end else begin
      shifted = clamped << (PrecW'(8) - p_eff);
    end
  end

  assign comp_o = shifted[CompW-1:0];

endmodule

>>> rtl/csrgb_ycc.sv
// BT.601 YCbCr to RGB conversion in Q.16 fixed point, or pass-through.
// Depends on csrgb_pkg for the coefficients, the saturation function and rgb_t.
`timescale 1ns / 1ps

module csrgb_ycc (
  input  logic [csrgb_pkg::CompW-1:0] c0_i,
  input  logic [csrgb_pkg::CompW-1:0] c1_i,
  input  logic [csrgb_pkg::CompW-1:0] c2_i,
  input  logic                        convert_i,
  output csrgb_pkg::rgb_t             rgb_o
);
  import csrgb_pkg::*;

  logic signed [SumW-1:0] y_w;
  logic signed [SumW-1:0] cb_w;
  logic signed [SumW-1:0] cr_w;
  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] sum_g;
  logic signed [SumW-1:0] sum_b;

  assign y_w  = signed'(SumW'({c0_i, 16'h0000}));
  assign cb_w = signed'(SumW'(c1_i)) - ChromaOffset;
  assign cr_w = signed'(SumW'(c2_i)) - ChromaOffset;

  // All sums stay well inside 27 bits for 8-bit components.
  assign sum_r = y_w + CoefCrR * cr_w;
  assign sum_g = y_w - CoefCbG * cb_w - CoefCrG * cr_w;
  assign sum_b = y_w + CoefCbB * cb_w;

  always_comb begin
    if (convert_i) begin
      rgb_o.red   = q16_to_byte(sum_r);
      rgb_o.green = q16_to_byte(sum_g);
      rgb_o.blue  = q16_to_byte(sum_b);
    end else begin
      rgb_o.red   = c0_i;
      rgb_o.green = c1_i;
      rgb_o.blue  = c2_i;
    end
  end

endmodule

>>> rtl/component_sample_to_rgb8.sv
// Top level of the component sample to RGB8 converter: config registers and pipeline.
// Depends on csrgb_pkg, csrgb_scale and csrgb_ycc.
`timescale 1ns / 1ps

// Usage:
// One input beat carries one pixel of three raw samples (raw_first_i, raw_second_i,
// raw_third_i); one output beat carries the 8-bit red, green and blue values.
// Both channels move a beat when valid is high and stall is low at a clock edge.
// The pipeline has two registers: raw samples and result. Scaling and color
// conversion sit in one combinational pass between them, and one beat per cycle
// is sustained while the receiver does not stall. When the receiver stalls, the
// result is held and the input register still takes one more beat; in_stall_o
// rises only once both registers hold a beat.
// Configuration goes through the APB-style port at byte addresses 0, 4, 8, 12, 16
// (first, second, third precision, signed mask, YCbCr convert enable). Writes
// are meant to happen while the pipeline is empty. pready is always high.
// Reset empties the pipeline and sets all precisions to 8, the signed mask to 0
// and conversion off.
module component_sample_to_rgb8 #(
  parameter int unsigned MAX_PREC = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [csrgb_pkg::RawW-1:0]  raw_first_i,
  input  logic signed [csrgb_pkg::RawW-1:0]  raw_second_i,
  input  logic signed [csrgb_pkg::RawW-1:0]  raw_third_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [csrgb_pkg::CompW-1:0]        red_out_o,
  output logic [csrgb_pkg::CompW-1:0]        green_out_o,
  output logic [csrgb_pkg::CompW-1:0]        blue_out_o
);
  import csrgb_pkg::*;

  logic [PrecW-1:0] prec_first_q;
  logic [PrecW-1:0] prec_second_q;
  logic [PrecW-1:0] prec_third_q;
  logic [2:0]       signed_mask_q;
  logic             ycc_convert_q;

  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_first_q  <= PrecW'(8);
      prec_second_q <= PrecW'(8);
      prec_third_q  <= PrecW'(8);
      signed_mask_q <= '0;
      ycc_convert_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegPrecFirst:  prec_first_q  <= pwdata[PrecW-1:0];
        RegPrecSecond: prec_second_q <= pwdata[PrecW-1:0];
        RegPrecThird:  prec_third_q  <= pwdata[PrecW-1:0];
        RegSignedMask: signed_mask_q <= pwdata[2:0];
        RegYccConvert: ycc_convert_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPrecFirst:  prdata = 32'(prec_first_q);
      RegPrecSecond: prdata = 32'(prec_second_q);
      RegPrecThird:  prdata = 32'(prec_third_q);
      RegSignedMask: prdata = 32'(signed_mask_q);
      RegYccConvert: prdata = 32'(ycc_convert_q);
      default:       prdata = '0;
    endcase
  end

  // Pipeline control: each stage advances when it is empty or the next one moves.
  logic v0_q, out_valid_q;
  logic en0, en1;

  assign en1        = !out_valid_q || !out_stall_i;
  assign en0        = !v0_q || en1;
  assign in_stall_o = !en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= in_valid_i;
      end
      if (en1) begin
        out_valid_q <= v0_q;
      end
    end
  end

  logic signed [RawW-1:0] raw0_q, raw1_q, raw2_q;
  logic [CompW-1:0]       c0_d, c1_d, c2_d;
  rgb_t                   rgb_d;
  rgb_t                   rgb_q;

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      raw0_q <= raw_first_i;
      raw1_q <= raw_second_i;
      raw2_q <= raw_third_i;
    end
    if (en1 && v0_q) begin
      rgb_q <= rgb_d;
    end
  end

  csrgb_scale #(.MaxPrec(MAX_PREC)) u_scale0 (
    .raw_i (raw0_q),
    .prec_i(prec_first_q),
    .sgn_i (signed_mask_q[0]),
    .comp_o(c0_d)
  );

  csrgb_scale #(.MaxPrec(MAX_PREC)) u_scale1 (
    .raw_i (raw1_q),
    .prec_i(prec_second_q),
    .sgn_i (signed_mask_q[1]),
    .comp_o(c1_d)
  );

  csrgb_scale #(.MaxPrec(MAX_PREC)) u_scale2 (
    .raw_i (raw2_q),
    .prec_i(prec_third_q),
    .sgn_i (signed_mask_q[2]),
    .comp_o(c2_d)
  );

  csrgb_ycc u_ycc (
    .c0_i     (c0_d),
    .c1_i     (c1_d),
    .c2_i     (c2_d),
    .convert_i(ycc_convert_q),
    .rgb_o    (rgb_d)
  );

  assign out_valid_o = out_valid_q;
  assign red_out_o   = rgb_q.red;
  assign green_out_o = rgb_q.green;
  assign blue_out_o  = rgb_q.blue;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v0_q)
    else $error("accepted beat did not enter the first stage");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v0_q && out_valid_q && out_stall_i)
    else $error("input stalled while the pipeline has room");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v0_q && en1 && !ycc_convert_q |=> red_out_o == $past(c0_d)
      && blue_out_o == $past(c2_d))
    else $error("pass-through result differs from the scaled samples");

  a_prec_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && reg_idx == RegPrecFirst |=> prec_first_q == $past(pwdata[PrecW-1:0]))
    else $error("precision register write was lost");
`endif

endmodule
